### design/ctt_pkg.sv
// Package for the configuration text tokenizer: token kinds, lexer modes,
// number bases and the result record. No dependencies.
`timescale 1ns / 1ps
package ctt_pkg;

   localparam int MaxTextBytes = 65536;
   localparam int PosW = $clog2(MaxTextBytes) + 1;

   typedef enum logic [3:0] {
      TK_NEWLINE = 4'd0, TK_EQUAL = 4'd1, TK_BRACE_OPEN = 4'd2, TK_BRACE_CLOSE = 4'd3,
      TK_BRACKET_OPEN = 4'd4, TK_BRACKET_CLOSE = 4'd5, TK_COMMA = 4'd6, TK_DOT = 4'd7,
      TK_KEY = 4'd8, TK_BOOL = 4'd9, TK_INT = 4'd10, TK_FLOAT = 4'd11,
      TK_STRING = 4'd12, TK_ERROR = 4'd13, TK_END = 4'd14
   } kind_type;

   typedef enum logic [2:0] {
      MODE_IDLE, MODE_COMMENT, MODE_IDENT, MODE_NUM_ZERO, MODE_NUM_BODY,
      MODE_STRING, MODE_DONE
   } mode_type;

   typedef enum logic [1:0] {
      BASE_DEC = 2'd0, BASE_BIN = 2'd1, BASE_OCT = 2'd2, BASE_HEX = 2'd3
   } base_type;

   localparam logic [3:0] KwTrueDone  = 4'd4;
   localparam logic [3:0] KwFalseDone = 4'd9;

   typedef struct packed {
      logic [3:0]  token_kind;
      logic [15:0] head_line;
      logic [15:0] start_column;
      logic [15:0] tail_line;
      logic [15:0] end_column;
      logic [63:0] integer_value;
      logic        bool_value;
      logic [15:0] text_offset;
      logic [16:0] text_length;
      logic        last_of_run;
   } token_type;

   function automatic logic [4:0] digit_value(input logic [7:0] c);
      logic [4:0] d;
      d = 5'd31;
      if (c >= "0" && c <= "9") d = 5'(c - "0");
      else if (c >= "a" && c <= "f") d = 5'(c - "a" + 8'd10);
      else if (c >= "A" && c <= "F") d = 5'(c - "A" + 8'd10);
      return d;
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

endpackage

### design/config_text_tokenizer.sv
// Top level of the configuration text tokenizer: lexer core and result
// queue. Depends on ctt_pkg, ctt_lexer and ctt_out_queue.
// Tokens are registered in the result queue when the byte that gives them is accepted.
// Throughput: one byte per cycle while results are taken each cycle and the queue
// holds two tokens or fewer; a byte giving two tokens may stall input as the queue drains.
// Reset: synchronous, active high; line 1, column 0, empty queue.
`timescale 1ns / 1ps
module config_text_tokenizer
   import ctt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // text_byte
   input  logic         req_tlast,   // end_of_text
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [167:0] rsp_tdata,   // start line, start_column, end line,
                                     // end_column, integer_value, bool_value,
                                     // text_offset, text_length, zero fill
   output logic [3:0]   rsp_tuser,   // token_kind
   output logic         rsp_tlast    // last_of_run
);

   logic       step, room;
   logic [1:0] count;
   token_type  tok0, tok1, out_tok;

   assign req_tready = room;
   assign step = req_tvalid && req_tready;

   ctt_lexer u_lexer (
      .clock(clock), .reset(reset), .step(step),
      .text_byte(req_tdata), .end_of_text(req_tlast),
      .count(count), .tok0(tok0), .tok1(tok1)
   );

   ctt_out_queue u_queue (
      .clock(clock), .reset(reset), .push(step), .count(count),
      .tok0(tok0), .tok1(tok1), .room(room),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_token(out_tok)
   );

   assign rsp_tdata = {6'd0, out_tok.text_length, out_tok.text_offset,
                       out_tok.bool_value, out_tok.integer_value, out_tok.end_column,
                       out_tok.tail_line, out_tok.start_column, out_tok.head_line};
   assign rsp_tuser = out_tok.token_kind;
   assign rsp_tlast = out_tok.last_of_run;

endmodule

### design/ctt_lexer.sv
// Lexer core: per-byte state update and token generation, at most two
// tokens per byte. Depends on ctt_pkg.
`timescale 1ns / 1ps
module ctt_lexer
   import ctt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] text_byte,
   input  logic       end_of_text,
   output logic [1:0] count,
   output token_type  tok0,
   output token_type  tok1
);

   mode_type    mode_ff, mode_in;
   logic [15:0] line_ff, line_in, col_ff, col_in;
   logic [PosW-1:0] pos_ff, pos_in;
   logic [15:0] sline_ff, sline_in, scol_ff, scol_in;
   logic [PosW-1:0] soff_ff, soff_in;
   logic [63:0] acc_ff, acc_in;
   base_type    base_ff, base_in;
   logic        neg_ff, neg_in;
   logic [1:0]  dots_ff, dots_in;
   logic        us_ff, us_in, ovf_ff, ovf_in, stop_ff, stop_in;
   logic [3:0]  kw_ff, kw_in;

   logic [7:0]  c;
   logic        ident_char, number_char, is_punct, is_space;
   logic [3:0]  punct_kind;
   logic [4:0]  dig;
   logic [4:0]  radix;
   logic [63:0] limit, sum;
   logic        ovf_mul, over;
   logic [16:0] len_full;
   logic [15:0] off_clamp;
   logic [15:0] adv_line, adv_col;
   logic [PosW-1:0] adv_pos;

   always_comb begin
      c = text_byte;
      dig = digit_value(c);
      ident_char = is_alpha(c) || (c >= "0" && c <= "9") || c == "_" || c == "-";
      number_char = dig < 5'd16 || c == "_" || c == ".";
      is_space = c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0B || c == 8'h0C;
      is_punct = 1'b1;
      case (c)
         8'h0A:   punct_kind = TK_NEWLINE;
         "=":     punct_kind = TK_EQUAL;
         "{":     punct_kind = TK_BRACE_OPEN;
         "}":     punct_kind = TK_BRACE_CLOSE;
         "[":     punct_kind = TK_BRACKET_OPEN;
         "]":     punct_kind = TK_BRACKET_CLOSE;
         ",":     punct_kind = TK_COMMA;
         ".":     punct_kind = TK_DOT;
         default: begin
            punct_kind = TK_NEWLINE;
            is_punct = 1'b0;
         end
      endcase
      adv_pos = (pos_ff < PosW'(MaxTextBytes)) ? pos_ff + 1'b1 : pos_ff;
      if (c == 8'h0A) begin
         adv_line = (line_ff != 16'hFFFF) ? line_ff + 16'd1 : line_ff;
         adv_col = '0;
      end else begin
         adv_line = line_ff;
         adv_col = (col_ff != 16'hFFFF) ? col_ff + 16'd1 : col_ff;
      end
      len_full = 17'(pos_ff - soff_ff);
      off_clamp = (soff_ff > PosW'(16'hFFFF)) ? 16'hFFFF : soff_ff[15:0];
   end

   // Digit accumulation: radixes are powers of two or ten, so shifts and adds.
   always_comb begin
      logic [67:0] wide;
      logic [67:0] tot;
      case (base_ff)
         BASE_BIN: begin
            radix = 5'd2;
            wide = {4'b0, acc_ff} << 1;
         end
         BASE_OCT: begin
            radix = 5'd8;
            wide = {4'b0, acc_ff} << 3;
         end
         BASE_HEX: begin
            radix = 5'd16;
            wide = {4'b0, acc_ff} << 4;
         end
         default: begin
            radix = 5'd10;
            wide = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1);
         end
      endcase
      limit = neg_ff ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF;
      tot = wide + {63'b0, dig};
      ovf_mul = |wide[67:64];
      sum = tot[63:0];
      over = (|tot[67:64]) || (sum > limit);
   end

   function automatic token_type mk(input logic [3:0] k, input logic [15:0] sl,
                                    input logic [15:0] sc, input logic [63:0] iv,
                                    input logic bv, input logic [15:0] off,
                                    input logic [16:0] ln, input logic [15:0] el,
                                    input logic [15:0] ec);
      token_type t;
      t.token_kind = k;
      t.head_line = sl;
      t.start_column = sc;
      t.tail_line = el;
      t.end_column = ec;
      t.integer_value = iv;
      t.bool_value = bv;
      t.text_offset = off;
      t.text_length = ln;
      t.last_of_run = 1'b0;
      return t;
   endfunction

   always_comb begin
      token_type pend, idl;
      logic has_pend, has_idl, go_idle;
      logic take_start;
      mode_in = mode_ff; line_in = line_ff; col_in = col_ff; pos_in = pos_ff;
      sline_in = sline_ff; scol_in = scol_ff; soff_in = soff_ff;
      acc_in = acc_ff; base_in = base_ff; neg_in = neg_ff; dots_in = dots_ff;
      us_in = us_ff; ovf_in = ovf_ff; stop_in = stop_ff; kw_in = kw_ff;
      pend = '0; idl = '0; has_pend = 1'b0; has_idl = 1'b0; go_idle = 1'b0;
      take_start = 1'b0;
      count = 2'd0;
      tok0 = '0;
      tok1 = '0;

      // Pending token as it would be finished now.
      if (mode_ff == MODE_IDENT) begin
         has_pend = 1'b1;
         if (kw_ff == KwTrueDone)
            pend = mk(TK_BOOL, sline_ff, scol_ff, '0, 1'b1, '0, '0, line_ff, col_ff);
         else if (kw_ff == KwFalseDone)
            pend = mk(TK_BOOL, sline_ff, scol_ff, '0, 1'b0, '0, '0, line_ff, col_ff);
         else
            pend = mk(TK_KEY, sline_ff, scol_ff, '0, 1'b0, off_clamp, len_full,
                      line_ff, col_ff);
      end else if (mode_ff == MODE_NUM_ZERO || mode_ff == MODE_NUM_BODY) begin
         has_pend = 1'b1;
         if (dots_ff >= 2'd2 || us_ff)
            pend = mk(TK_ERROR, sline_ff, scol_ff, '0, 1'b0, '0, '0, line_ff, col_ff);
         else if (dots_ff == 2'd1)
            pend = mk(TK_FLOAT, sline_ff, scol_ff, '0, 1'b0, off_clamp, len_full,
                      line_ff, col_ff);
         else if (ovf_ff)
            pend = mk(TK_ERROR, sline_ff, scol_ff, '0, 1'b0, '0, '0, line_ff, col_ff);
         else
            pend = mk(TK_INT, sline_ff, scol_ff, neg_ff ? 64'd0 - acc_ff : acc_ff,
                      1'b0, '0, '0, line_ff, col_ff);
      end else if (mode_ff == MODE_STRING) begin
         has_pend = 1'b1;
         pend = mk(TK_ERROR, sline_ff, scol_ff, '0, 1'b0, '0, '0, line_ff, col_ff);
      end

      // Result of the byte in idle mode (positions after advance).
      if (is_punct) begin
         has_idl = 1'b1;
         idl = mk(punct_kind, line_ff, col_ff, '0, 1'b0, '0, '0, adv_line, adv_col);
      end else if (!(c == "#" || is_space || is_alpha(c) || c == "_" ||
                     (c >= "0" && c <= "9") || c == "-" || c == "\"")) begin
         has_idl = 1'b1;
         idl = mk(TK_ERROR, line_ff, col_ff, '0, 1'b0, '0, '0, adv_line, adv_col);
      end

      if (mode_ff == MODE_DONE) begin
         count = 2'd1;
         tok0 = mk(TK_END, line_ff, col_ff, '0, 1'b0, '0, '0, line_ff, col_ff);
      end else if (end_of_text || c == 8'h00) begin
         mode_in = MODE_DONE;
         if (has_pend) begin
            count = 2'd2;
            tok0 = pend;
            tok1 = mk(TK_END, line_ff, col_ff, '0, 1'b0, '0, '0, line_ff, col_ff);
         end else begin
            count = 2'd1;
            tok0 = mk(TK_END, line_ff, col_ff, '0, 1'b0, '0, '0, line_ff, col_ff);
         end
      end else if (mode_ff == MODE_COMMENT) begin
         if (c == 8'h0A) begin
            go_idle = 1'b1;
         end else begin
            line_in = adv_line; col_in = adv_col; pos_in = adv_pos;
         end
      end else if (mode_ff == MODE_STRING) begin
         line_in = adv_line; col_in = adv_col; pos_in = adv_pos;
         if (c == "\"") begin
            mode_in = MODE_IDLE;
            count = 2'd1;
            tok0 = mk(TK_STRING, sline_ff, scol_ff, '0, 1'b0, off_clamp, len_full,
                      adv_line, adv_col);
         end
      end else if (mode_ff == MODE_IDENT) begin
         if (ident_char) begin
            if (kw_ff == 4'd1 && c == "r") kw_in = 4'd2;
            else if (kw_ff == 4'd2 && c == "u") kw_in = 4'd3;
            else if (kw_ff == 4'd3 && c == "e") kw_in = 4'd4;
            else if (kw_ff == 4'd5 && c == "a") kw_in = 4'd6;
            else if (kw_ff == 4'd6 && c == "l") kw_in = 4'd7;
            else if (kw_ff == 4'd7 && c == "s") kw_in = 4'd8;
            else if (kw_ff == 4'd8 && c == "e") kw_in = 4'd9;
            else kw_in = 4'd0;
            line_in = adv_line; col_in = adv_col; pos_in = adv_pos;
         end else begin
            go_idle = 1'b1;
         end
      end else if (mode_ff == MODE_NUM_ZERO || mode_ff == MODE_NUM_BODY) begin
         if (mode_ff == MODE_NUM_ZERO && (c == "b" || c == "o" || c == "x")) begin
            base_in = (c == "b") ? BASE_BIN : ((c == "o") ? BASE_OCT : BASE_HEX);
            mode_in = MODE_NUM_BODY;
            line_in = adv_line; col_in = adv_col; pos_in = adv_pos;
         end else if (number_char) begin
            mode_in = MODE_NUM_BODY;
            line_in = adv_line; col_in = adv_col; pos_in = adv_pos;
            if (c == "_") begin
               us_in = 1'b1;
            end else begin
               us_in = 1'b0;
               if (c == ".") begin
                  if (dots_ff < 2'd2) dots_in = dots_ff + 2'd1;
                  stop_in = 1'b1;
               end else if (!stop_ff) begin
                  if (dig >= radix) stop_in = 1'b1;
                  else if (ovf_mul || over) ovf_in = 1'b1;
                  else acc_in = sum;
               end
            end
         end else begin
            go_idle = 1'b1;
         end
      end else begin
         go_idle = 1'b1;
      end

      if (go_idle) begin
         mode_in = MODE_IDLE;
         line_in = adv_line; col_in = adv_col; pos_in = adv_pos;
         if (c == "#") begin
            mode_in = MODE_COMMENT;
         end else if (is_alpha(c) || c == "_") begin
            take_start = 1'b1;
            mode_in = MODE_IDENT;
            kw_in = (c == "t") ? 4'd1 : ((c == "f") ? 4'd5 : 4'd0);
         end else if ((c >= "0" && c <= "9") || c == "-") begin
            take_start = 1'b1;
            base_in = BASE_DEC; neg_in = c == "-"; dots_in = '0;
            us_in = 1'b0; ovf_in = 1'b0; stop_in = 1'b0;
            acc_in = (c == "-" || c == "0") ? 64'd0 : {60'd0, dig[3:0]};
            mode_in = (c == "0") ? MODE_NUM_ZERO : MODE_NUM_BODY;
         end else if (c == "\"") begin
            take_start = 1'b1;
            mode_in = MODE_STRING;
         end
         if (take_start) begin
            sline_in = line_ff; scol_in = col_ff;
            soff_in = (c == "\"") ? adv_pos : pos_ff;
         end
         if (has_pend && mode_ff != MODE_COMMENT && mode_ff != MODE_IDLE) begin
            tok0 = pend;
            if (has_idl) begin
               tok1 = idl;
               count = 2'd2;
            end else begin
               count = 2'd1;
            end
         end else if (has_idl) begin
            tok0 = idl;
            count = 2'd1;
         end
      end
      if (count == 2'd1) tok0.last_of_run = 1'b1;
      if (count == 2'd2) tok1.last_of_run = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         line_ff <= 16'd1; col_ff <= '0; pos_ff <= '0;
         sline_ff <= 16'd1; scol_ff <= '0; soff_ff <= '0;
         acc_ff <= '0; base_ff <= BASE_DEC; neg_ff <= 1'b0; dots_ff <= '0;
         us_ff <= 1'b0; ovf_ff <= 1'b0; stop_ff <= 1'b0; kw_ff <= '0;
      end else if (step) begin
         mode_ff <= mode_in;
         line_ff <= line_in; col_ff <= col_in; pos_ff <= pos_in;
         sline_ff <= sline_in; scol_ff <= scol_in; soff_ff <= soff_in;
         acc_ff <= acc_in; base_ff <= base_in; neg_ff <= neg_in; dots_ff <= dots_in;
         us_ff <= us_in; ovf_ff <= ovf_in; stop_ff <= stop_in; kw_ff <= kw_in;
      end
   end

endmodule

### design/ctt_out_queue.sv
// Result queue holding up to four tokens so that a byte's two tokens can be
// taken while earlier ones drain. Depends on ctt_pkg.
`timescale 1ns / 1ps
module ctt_out_queue
   import ctt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  logic [1:0] count,
   input  token_type  tok0,
   input  token_type  tok1,
   output logic       room,
   output logic       out_valid,
   input  logic       out_ready,
   output token_type  out_token
);

   token_type   slot_ff [4];
   logic [1:0]  rd_ff, wr_ff;
   logic [2:0]  fill_ff, fill_in;
   logic        pop;
   logic [1:0]  n_push;

   assign pop = out_valid && out_ready;
   assign n_push = push ? count : 2'd0;
   assign out_valid = fill_ff != 3'd0;
   assign out_token = slot_ff[rd_ff];
   // Room for two, judged from the fill level alone without this cycle's pop.
   assign room = fill_ff <= 3'd2;
   assign fill_in = fill_ff + {1'b0, n_push} - {2'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= '0; wr_ff <= '0; fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
         if (pop) rd_ff <= rd_ff + 2'd1;
         wr_ff <= wr_ff + n_push;
      end
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) slot_ff[wr_ff] <= tok0;
      if (n_push == 2'd2) slot_ff[wr_ff + 2'd1] <= tok1;
   end

endmodule
